>>> hw/rtl/qr_function_module_mask_assert.svh
// Assertion macros used by the checker of this block.
`ifndef QR_FUNCTION_MODULE_MASK_ASSERT_SVH
`define QR_FUNCTION_MODULE_MASK_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define QRFM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrfm: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define QRFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrfm: next-cycle check failed");

`endif

>>> hw/rtl/qrfm_pkg.sv
package qrfm_pkg;

  localparam int unsigned VersionMin = 1;
  localparam int unsigned VersionMax = 40;
  localparam int unsigned NumVersions = VersionMax - VersionMin + 1;
  localparam int unsigned NumCenters = 7;

  typedef logic [7:0] coord_t;

  // Request and result payloads
  typedef struct packed {
    logic [5:0] symbol_version;
    logic [7:0] module_col;
    logic [7:0] module_row;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic       coord_valid;
    logic [7:0] side_length;
  } out_item_t;

  // Decoded version plus coordinates, first pipeline register
  typedef struct packed {
    logic                         ver_ok;
    logic                         ver7;
    coord_t                       col;
    coord_t                       row;
    coord_t                       side;
    coord_t                       side_m7;
    coord_t                       side_m8;
    coord_t                       side_m11;
    logic [NumCenters-1:0][7:0]   centers;
    logic [2:0]                   n_centers;
  } dec_t;

  // Fixed-region classification
  typedef struct packed {
    logic in_symbol;
    logic fixed_func;
  } region_t;

  // Second pipeline register
  typedef struct packed {
    logic                  coord_valid;
    coord_t                side;
    logic                  fixed_func;
    logic [NumCenters-1:0] near_x;
    logic [NumCenters-1:0] near_y;
    logic [NumCenters-1:0] last;
  } st2_t;

  // Alignment center coordinates per version, row = version - 1, zero = unused
  localparam logic [7:0] ALIGN_POS [NumVersions][NumCenters] = '{
    '{0,0,0,0,0,0,0},          '{6,18,0,0,0,0,0},         '{6,22,0,0,0,0,0},
    '{6,26,0,0,0,0,0},         '{6,30,0,0,0,0,0},         '{6,34,0,0,0,0,0},
    '{6,22,38,0,0,0,0},        '{6,24,42,0,0,0,0},        '{6,26,46,0,0,0,0},
    '{6,28,50,0,0,0,0},        '{6,30,54,0,0,0,0},        '{6,32,58,0,0,0,0},
    '{6,34,62,0,0,0,0},        '{6,26,46,66,0,0,0},       '{6,26,48,70,0,0,0},
    '{6,26,50,74,0,0,0},       '{6,30,54,78,0,0,0},       '{6,30,56,82,0,0,0},
    '{6,30,58,86,0,0,0},       '{6,34,62,90,0,0,0},       '{6,28,50,72,94,0,0},
    '{6,26,50,74,98,0,0},      '{6,30,54,78,102,0,0},     '{6,28,54,80,106,0,0},
    '{6,32,58,84,110,0,0},     '{6,30,58,86,114,0,0},     '{6,34,62,90,118,0,0},
    '{6,26,50,74,98,122,0},    '{6,30,54,78,102,126,0},   '{6,26,52,78,104,130,0},
    '{6,30,56,82,108,134,0},   '{6,34,60,86,112,138,0},   '{6,30,58,86,114,142,0},
    '{6,34,62,90,118,146,0},   '{6,30,54,78,102,126,150}, '{6,24,50,76,102,128,154},
    '{6,28,54,80,106,132,158}, '{6,32,58,84,110,136,162}, '{6,26,54,82,110,138,166},
    '{6,30,58,86,114,142,170}
  };

  // Number of alignment centers per axis, version / 7 + 2, none below version 2
  function automatic logic [2:0] align_count(logic [5:0] ver);
    logic [2:0] cnt;
    if (ver < 6'd2) begin
      cnt = 3'd0;
    end else if (ver < 6'd7) begin
      cnt = 3'd2;
    end else if (ver < 6'd14) begin
      cnt = 3'd3;
    end else if (ver < 6'd21) begin
      cnt = 3'd4;
    end else if (ver < 6'd28) begin
      cnt = 3'd5;
    end else if (ver < 6'd35) begin
      cnt = 3'd6;
    end else begin
      cnt = 3'd7;
    end
    return cnt;
  endfunction

endpackage

>>> hw/rtl/qr_function_module_mask.sv
// QR function-module mask.
// A request carries a symbol version and one module coordinate (column, row);
// the result says whether that module holds data, whether the coordinate lies
// inside a symbol of a legal version, and the symbol side length.
// Both channels use valid/ready; a request is taken when in_valid_i and
// in_ready_o are high at a clock edge, a result when out_valid_o and
// out_ready_i are high.
// A taken request moves through dec_q, st2_q and out_q in that order; its
// result is shown from out_q. Throughput: one request per cycle while the
// receiver takes results; three register stages (version decode and center
// lookup, region compares, alignment pair merge) each hold one item.
// When the receiver stalls, the pipeline fills its empty stages and then drops
// in_ready_o; the waiting result holds steady and nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties all stages; no result is shown
// until new requests arrive. The block keeps no state between requests.
module qr_function_module_mask (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  qrfm_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output qrfm_pkg::out_item_t  out_data_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  qrfm_pkg::dec_t    dec_d, dec_q;
  qrfm_pkg::region_t region;
  qrfm_pkg::st2_t    st2_d, st2_q;
  qrfm_pkg::out_item_t out_d, out_q;

  logic [5:0] ver;
  logic [5:0] ver_idx;
  logic       ver_ok;
  logic [7:0] ver_x4;
  logic       align_hit;

  // Advance each stage when the one after it can take its item
  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: decode version, look up alignment centers
  assign ver     = in_data_i.symbol_version;
  assign ver_ok  = (ver >= 6'(qrfm_pkg::VersionMin)) && (ver <= 6'(qrfm_pkg::VersionMax));
  assign ver_idx = ver_ok ? (ver - 6'(qrfm_pkg::VersionMin)) : 6'd0;
  assign ver_x4  = {ver, 2'b00};

  always_comb begin
    dec_d.ver_ok    = ver_ok;
    dec_d.ver7      = ver >= 6'd7;
    dec_d.col       = in_data_i.module_col;
    dec_d.row       = in_data_i.module_row;
    dec_d.side      = ver_ok ? (ver_x4 + 8'd17) : 8'd0;
    dec_d.side_m7   = ver_x4 + 8'd10;
    dec_d.side_m8   = ver_x4 + 8'd9;
    dec_d.side_m11  = ver_x4 + 8'd6;
    dec_d.n_centers = ver_ok ? qrfm_pkg::align_count(ver) : 3'd0;
    for (int i = 0; i < qrfm_pkg::NumCenters; i++) begin
      dec_d.centers[i] = qrfm_pkg::ALIGN_POS[ver_idx][i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) dec_q <= dec_d;
  end

  // Stage 2: fixed regions and per-center proximity
  qrfm_regions u_regions (
    .dec_i    (dec_q),
    .region_o (region)
  );

  always_comb begin
    st2_d.coord_valid = region.in_symbol;
    st2_d.side        = dec_q.side;
    st2_d.fixed_func  = region.fixed_func;
    for (int i = 0; i < qrfm_pkg::NumCenters; i++) begin
      st2_d.near_x[i] = (3'(i) < dec_q.n_centers) &&
                        ({1'b0, dec_q.col} + 9'd2 >= {1'b0, dec_q.centers[i]}) &&
                        ({1'b0, dec_q.col} <= {1'b0, dec_q.centers[i]} + 9'd2);
      st2_d.near_y[i] = (3'(i) < dec_q.n_centers) &&
                        ({1'b0, dec_q.row} + 9'd2 >= {1'b0, dec_q.centers[i]}) &&
                        ({1'b0, dec_q.row} <= {1'b0, dec_q.centers[i]} + 9'd2);
      st2_d.last[i]   = (dec_q.n_centers != 3'd0) && (3'(i) == dec_q.n_centers - 3'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) st2_q <= st2_d;
  end

  // Stage 3: merge center pairs, drop the three finder-corner pairs
  always_comb begin
    align_hit = 1'b0;
    for (int i = 0; i < qrfm_pkg::NumCenters; i++) begin
      for (int j = 0; j < qrfm_pkg::NumCenters; j++) begin
        if (st2_q.near_x[i] && st2_q.near_y[j] &&
            !((i == 0 && j == 0) || (i == 0 && st2_q.last[j]) ||
              (st2_q.last[i] && j == 0))) begin
          align_hit = 1'b1;
        end
      end
    end
    out_d.coord_valid = st2_q.coord_valid;
    out_d.side_length = st2_q.side;
    out_d.is_data     = st2_q.coord_valid && !st2_q.fixed_func && !align_hit;
  end

  always_ff @(posedge clk_i) begin
    if (en3) out_q <= out_d;
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/qrfm_regions.sv
module qrfm_regions (
  input  qrfm_pkg::dec_t    dec_i,
  output qrfm_pkg::region_t region_o
);

  qrfm_pkg::coord_t x;
  qrfm_pkg::coord_t y;
  logic finder;
  logic separator;
  logic timing;
  logic format;
  logic dark;
  logic version_area;

  assign x = dec_i.col;
  assign y = dec_i.row;

  // Inside the symbol only with a good version (side is zero otherwise)
  assign region_o.in_symbol = dec_i.ver_ok && (x < dec_i.side) && (y < dec_i.side);

  // Three finder patterns
  assign finder = (x < 8'd7 && y < 8'd7) ||
                  (x >= dec_i.side_m7 && y < 8'd7) ||
                  (x < 8'd7 && y >= dec_i.side_m7);

  // Separators around the finders
  assign separator = (x == 8'd7 && y < 8'd8) ||
                     (y == 8'd7 && x < 8'd7) ||
                     (x == dec_i.side_m8 && y < 8'd8) ||
                     (y == 8'd7 && x >= dec_i.side_m7) ||
                     (y == dec_i.side_m8 && x < 8'd8) ||
                     (x == 8'd7 && y >= dec_i.side_m7);

  // Timing row and column
  assign timing = (y == 8'd6 && x >= 8'd8 && x < dec_i.side_m8) ||
                  (x == 8'd6 && y >= 8'd8 && y < dec_i.side_m8);

  // Format information areas
  assign format = (x == 8'd8 && y < 8'd6) ||
                  (x == 8'd8 && (y == 8'd7 || y == 8'd8)) ||
                  (x == 8'd7 && y == 8'd8) ||
                  (y == 8'd8 && x < 8'd6) ||
                  (y == 8'd8 && x >= dec_i.side_m8) ||
                  (x == 8'd8 && y >= dec_i.side_m7);

  assign dark = (x == 8'd8) && (y == dec_i.side_m8);

  // Version information blocks, version 7 and above
  assign version_area = dec_i.ver7 &&
      ((x >= dec_i.side_m11 && x < dec_i.side_m8 && y < 8'd6) ||
       (x < 8'd6 && y >= dec_i.side_m11 && y < dec_i.side_m8));

  assign region_o.fixed_func = finder | separator | timing | format | dark | version_area;

endmodule

>>> hw/rtl/qrfm_checker.sv
`include "qr_function_module_mask_assert.svh"

module qrfm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input qrfm_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input qrfm_pkg::out_item_t out_data_o
);

  logic in_stall;
  logic out_stall;
  logic res_data;
  logic res_valid;
  logic res_side_nz;
  logic side_legal;
  logic side_form;

  assign in_stall    = in_valid_i && !in_ready_o;
  assign out_stall   = out_valid_o && !out_ready_i;
  assign res_data    = out_valid_o && out_data_o.is_data;
  assign res_valid   = out_valid_o && out_data_o.coord_valid;
  assign res_side_nz = out_valid_o && (out_data_o.side_length != 8'd0);
  assign side_legal  = (out_data_o.side_length >= 8'd21) &&
                       (out_data_o.side_length <= 8'd177);
  assign side_form   = out_data_o.side_length[1:0] == 2'b01;

  // Hold a waiting request
  `QRFM_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_stall, in_valid_i && $stable(in_data_i))

  // Hold a stalled result
  `QRFM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))

  // Data modules only inside a symbol
  `QRFM_ASSERT_SAME(a_data_in_symbol, clk_i, rst_ni, res_data, out_data_o.coord_valid)

  // A valid coordinate comes with a legal side length
  `QRFM_ASSERT_SAME(a_side_range, clk_i, rst_ni, res_valid, side_legal)

  // Any nonzero side is one more than a multiple of four
  `QRFM_ASSERT_SAME(a_side_form, clk_i, rst_ni, res_side_nz, side_form)

endmodule

bind qr_function_module_mask qrfm_checker u_qrfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/sv/tb_qr_function_module_mask.sv
module tb_qr_function_module_mask;

  localparam int unsigned VER_LO = 1;
  localparam int unsigned VER_HI = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned NUM_RANDOM = 1300;

  // Alignment centers per version, row = version - 1, zero = unused
  localparam logic [7:0] CENTER_TAB [40][7] = '{
    '{0,0,0,0,0,0,0},          '{6,18,0,0,0,0,0},         '{6,22,0,0,0,0,0},
    '{6,26,0,0,0,0,0},         '{6,30,0,0,0,0,0},         '{6,34,0,0,0,0,0},
    '{6,22,38,0,0,0,0},        '{6,24,42,0,0,0,0},        '{6,26,46,0,0,0,0},
    '{6,28,50,0,0,0,0},        '{6,30,54,0,0,0,0},        '{6,32,58,0,0,0,0},
    '{6,34,62,0,0,0,0},        '{6,26,46,66,0,0,0},       '{6,26,48,70,0,0,0},
    '{6,26,50,74,0,0,0},       '{6,30,54,78,0,0,0},       '{6,30,56,82,0,0,0},
    '{6,30,58,86,0,0,0},       '{6,34,62,90,0,0,0},       '{6,28,50,72,94,0,0},
    '{6,26,50,74,98,0,0},      '{6,30,54,78,102,0,0},     '{6,28,54,80,106,0,0},
    '{6,32,58,84,110,0,0},     '{6,30,58,86,114,0,0},     '{6,34,62,90,118,0,0},
    '{6,26,50,74,98,122,0},    '{6,30,54,78,102,126,0},   '{6,26,52,78,104,130,0},
    '{6,30,56,82,108,134,0},   '{6,34,60,86,112,138,0},   '{6,30,58,86,114,142,0},
    '{6,34,62,90,118,146,0},   '{6,30,54,78,102,126,150}, '{6,24,50,76,102,128,154},
    '{6,28,54,80,106,132,158}, '{6,32,58,84,110,136,162}, '{6,26,54,82,110,138,166},
    '{6,30,58,86,114,142,170}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  qrfm_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  qrfm_pkg::out_item_t out_data_o;

  logic        idle_off = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt = 0;

  qr_function_module_mask DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Number of alignment centers per axis for a legal version
  function automatic int unsigned center_count(int unsigned v);
    int unsigned n;
    if (v < 2) return 0;
    n = v / 7 + 2;
    return (n > 7) ? 7 : n;
  endfunction

  function automatic bit in_rect(int unsigned x, int unsigned y, int unsigned bx,
                                 int unsigned by, int unsigned w, int unsigned h);
    return x >= bx && x < bx + w && y >= by && y < by + h;
  endfunction

  function automatic bit close_to(int unsigned p, int unsigned c);
    return p + 2 >= c && p <= c + 2;
  endfunction

  function automatic bit on_alignment(int unsigned v, int unsigned x, int unsigned y);
    int unsigned n, lo, hi, cx, cy;
    n = center_count(v);
    if (n == 0) return 1'b0;
    lo = CENTER_TAB[v-1][0];
    hi = CENTER_TAB[v-1][n-1];
    for (int i = 0; i < n; i++) begin
      cx = CENTER_TAB[v-1][i];
      for (int j = 0; j < n; j++) begin
        cy = CENTER_TAB[v-1][j];
        // skip the three centers that collide with finder corners
        if ((cx == lo && cy == lo) || (cx == lo && cy == hi) || (cx == hi && cy == lo))
          continue;
        if (close_to(x, cx) && close_to(y, cy)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit on_function(int unsigned v, int unsigned s, int unsigned x,
                                     int unsigned y);
    // finders
    if (in_rect(x, y, 0, 0, 7, 7) || in_rect(x, y, s-7, 0, 7, 7) ||
        in_rect(x, y, 0, s-7, 7, 7)) return 1'b1;
    // separators
    if (in_rect(x, y, 7, 0, 1, 8) || in_rect(x, y, 0, 7, 7, 1) ||
        in_rect(x, y, s-8, 0, 1, 8) || in_rect(x, y, s-7, 7, 7, 1) ||
        in_rect(x, y, 0, s-8, 8, 1) || in_rect(x, y, 7, s-7, 1, 7)) return 1'b1;
    // timing lines
    if (in_rect(x, y, 8, 6, s-16, 1) || in_rect(x, y, 6, 8, 1, s-16)) return 1'b1;
    // format areas
    if (in_rect(x, y, 8, 0, 1, 6) || in_rect(x, y, 8, 7, 1, 2) ||
        in_rect(x, y, 7, 8, 1, 1) || in_rect(x, y, 0, 8, 6, 1) ||
        in_rect(x, y, s-8, 8, 8, 1) || in_rect(x, y, 8, s-7, 1, 7)) return 1'b1;
    // dark module
    if (x == 8 && y == s-8) return 1'b1;
    // version areas
    if (v >= 7 && (in_rect(x, y, s-11, 0, 3, 6) || in_rect(x, y, 0, s-11, 6, 3)))
      return 1'b1;
    return on_alignment(v, x, y);
  endfunction

  // Compute the mask result for one request
  function automatic qrfm_pkg::out_item_t predict_mask(qrfm_pkg::in_item_t req);
    qrfm_pkg::out_item_t res;
    int unsigned         v, x, y, s;
    v = req.symbol_version;
    x = req.module_col;
    y = req.module_row;
    res = '0;
    if (v < VER_LO || v > VER_HI) return res;
    s = 17 + 4 * v;
    res.side_length = s[7:0];
    if (x >= s || y >= s) return res;
    res.coord_valid = 1'b1;
    res.is_data = !on_function(v, s, x, y);
    return res;
  endfunction

  class mask_scoreboard;
    qrfm_pkg::out_item_t expected_q[$];
    int unsigned         errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(qrfm_pkg::in_item_t req);
      expected_q = {expected_q, predict_mask(req)};
    endfunction

    function void check_result(qrfm_pkg::out_item_t got);
      qrfm_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no request pending, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.is_data !== want.is_data) begin
        $display("%0t: is_data expected %0d got %0d", $time, want.is_data, got.is_data);
        errors++;
      end
      if (got.coord_valid !== want.coord_valid) begin
        $display("%0t: coord_valid expected %0d got %0d", $time, want.coord_valid,
                 got.coord_valid);
        errors++;
      end
      if (got.side_length !== want.side_length) begin
        $display("%0t: side_length expected %0d got %0d", $time, want.side_length,
                 got.side_length);
        errors++;
      end
    endfunction
  endclass

  mask_scoreboard sb = new();

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_qr_function_module_mask NOT OK");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(0, 3);
    return $urandom_range(8, 40);
  endfunction

  // Throttle the result side
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!idle_off && $urandom_range(0, 99) < 25) begin
      out_ready_i <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Track accepted requests and check results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  function automatic qrfm_pkg::in_item_t make_req(int unsigned v, int unsigned x,
                                                  int unsigned y);
    qrfm_pkg::in_item_t req;
    req.symbol_version = v[5:0];
    req.module_col = x[7:0];
    req.module_row = y[7:0];
    return req;
  endfunction

  // Coordinate close to an alignment center, or anywhere for version 1
  function automatic int unsigned near_center_coord(int unsigned v);
    int unsigned n;
    n = center_count(v);
    if (n == 0) return $urandom_range(0, 20);
    return CENTER_TAB[v-1][$urandom_range(0, n-1)] + $urandom_range(0, 6) - 3;
  endfunction

  // Coordinate in the low or high border band of the symbol
  function automatic int unsigned border_coord(int unsigned s);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 11);
    return $urandom_range(s - 12, s - 1);
  endfunction

  function automatic qrfm_pkg::in_item_t random_req();
    int unsigned r, v, s;
    r = $urandom_range(0, 99);
    v = $urandom_range(VER_LO, VER_HI);
    s = 17 + 4 * v;
    if (r < 55) return make_req(v, $urandom_range(0, s-1), $urandom_range(0, s-1));
    if (r < 75) return make_req(v, near_center_coord(v), near_center_coord(v));
    if (r < 88) return make_req(v, border_coord(s), border_coord(s));
    if (r < 96) return make_req(v, $urandom_range(0, 255), $urandom_range(0, 255));
    return make_req($urandom_range(0, 63), $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // Present one request and hold it until taken
  task automatic send_request(input qrfm_pkg::in_item_t req);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Optionally idle the request side after a handshake
  task automatic request_gap();
    int unsigned gap;
    if (!idle_off && $urandom_range(0, 99) < 30) begin
      gap = pick_gap() + 1;
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    qrfm_pkg::in_item_t directed[$];

    // Corners, finders, timing, format, dark module, version and alignment areas
    directed = {directed, make_req(1, 0, 0)};
    directed = {directed, make_req(1, 20, 20)};
    directed = {directed, make_req(1, 8, 13)};
    directed = {directed, make_req(1, 9, 9)};
    directed = {directed, make_req(1, 21, 0)};
    directed = {directed, make_req(1, 0, 255)};
    directed = {directed, make_req(1, 255, 255)};
    directed = {directed, make_req(0, 5, 5)};
    directed = {directed, make_req(41, 5, 5)};
    directed = {directed, make_req(63, 255, 0)};
    directed = {directed, make_req(40, 176, 176)};
    directed = {directed, make_req(40, 177, 10)};
    directed = {directed, make_req(40, 170, 170)};
    directed = {directed, make_req(2, 18, 18)};
    directed = {directed, make_req(2, 16, 20)};
    directed = {directed, make_req(6, 30, 0)};
    directed = {directed, make_req(7, 34, 0)};
    directed = {directed, make_req(7, 0, 34)};
    directed = {directed, make_req(7, 22, 22)};
    directed = {directed, make_req(7, 38, 6)};
    directed = {directed, make_req(5, 10, 6)};
    directed = {directed, make_req(5, 6, 10)};
    directed = {directed, make_req(5, 8, 3)};
    directed = {directed, make_req(5, 34, 8)};
    directed = {directed, make_req(35, 150, 6)};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_request(directed[i]);
      request_gap();
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // run a stretch with no idling on either side
      if (i == 300) idle_off <= 1'b1;
      if (i == 450) idle_off <= 1'b0;
      // hold off new requests until the pipeline drains
      if (i == 700) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        wait_drained();
      end
      send_request(random_req());
      request_gap();
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_qr_function_module_mask OK");
    end else begin
      $display("tb_qr_function_module_mask NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/qrfm_pkg.sv
hw/rtl/qrfm_regions.sv
hw/rtl/qr_function_module_mask.sv
hw/rtl/qrfm_checker.sv
tb/sv/tb_qr_function_module_mask.sv
